// File: design/rar_pkg.sv
package rar_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 16;
   localparam int RES_NUM_WIDTH         = 32;
   localparam int RES_DEN_WIDTH         = 31;
   localparam int STATUS_WIDTH          = 2;
   localparam int OPCODE_WIDTH          = 2;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STS_OK       = 2'd0,
      STS_ZERO_DEN = 2'd1,
      STS_DIV_ZERO = 2'd2
   } status_type;

   // which cross product the shared multiplier forms this cycle
   typedef enum logic [1:0] {
      MS_AX = 2'd0,   // left_num * (right_num for multiply, else right_den)
      MS_BC = 2'd1,   // left_den * right_num
      MS_BD = 2'd2    // left_den * right_den
   } mul_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_AX,
      S_MUL_BC,
      S_MUL_BD,
      S_FORM,
      S_CHECK,
      S_GCD,
      S_DIV,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        form;
      logic        gcd_step;
      logic        div_init;
      logic        div_step;
      logic        finish;
   } dp_cmd_type;

   typedef struct packed {
      logic bad_input;
      logic num_zero;
      logic gcd_done;
   } dp_status_type;

endpackage

// File: design/rar_datapath.sv
module rar_datapath import rar_pkg::*; #(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic [OPCODE_WIDTH-1:0]         opcode,
   input  logic signed [OPERAND_WIDTH-1:0] left_num,
   input  logic [OPERAND_WIDTH-2:0]        left_den,
   input  logic signed [OPERAND_WIDTH-1:0] right_num,
   input  logic [OPERAND_WIDTH-2:0]        right_den,
   input  dp_cmd_type                      cmd,
   output dp_status_type                   status,
   output logic [RES_NUM_WIDTH-1:0]        result_num,
   output logic [RES_DEN_WIDTH-1:0]        result_den,
   output logic [STATUS_WIDTH-1:0]         result_status
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;          // signed product / cross sum
   localparam int MW = 2 * W - 1;      // magnitudes of numerator and denominator
   localparam int KW = $clog2(MW + 1);

   // operand capture
   opcode_type               op_ff;
   logic signed [W-1:0]      a_ff, c_ff;
   logic [W-2:0]             b_ff, d_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= opcode_type'(opcode);
         a_ff  <= left_num;
         b_ff  <= left_den;
         c_ff  <= right_num;
         d_ff  <= right_den;
      end
   end

   // input error code
   status_type err_w;
   always_comb begin
      if (b_ff == '0 || d_ff == '0) begin
         err_w = STS_ZERO_DEN;
      end else if (op_ff == OP_DIV && c_ff == '0) begin
         err_w = STS_DIV_ZERO;
      end else begin
         err_w = STS_OK;
      end
   end

   // shared multiplier, one product per cycle
   logic signed [W-1:0]  opa_w, opb_w;
   logic signed [PW-1:0] prod_w;
   logic signed [PW-1:0] p1_ff, p2_ff, p3_ff;

   always_comb begin
      case (cmd.mul_sel)
         MS_AX: begin
            opa_w = a_ff;
            opb_w = (op_ff == OP_MUL) ? c_ff : signed'({1'b0, d_ff});
         end
         MS_BC: begin
            opa_w = signed'({1'b0, b_ff});
            opb_w = c_ff;
         end
         default: begin
            opa_w = signed'({1'b0, b_ff});
            opb_w = signed'({1'b0, d_ff});
         end
      endcase
   end

   assign prod_w = opa_w * opb_w;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MS_AX:   p1_ff <= prod_w;
            MS_BC:   p2_ff <= prod_w;
            default: p3_ff <= prod_w;
         endcase
      end
   end

   // cross numerator / denominator, split into sign and magnitude
   logic signed [PW-1:0] num_w, den_w, num_abs_w, den_abs_w;

   always_comb begin
      case (op_ff)
         OP_ADD:  num_w = p1_ff + p2_ff;
         OP_SUB:  num_w = p1_ff - p2_ff;
         default: num_w = p1_ff;
      endcase
      den_w     = (op_ff == OP_DIV) ? p2_ff : p3_ff;
      num_abs_w = num_w[PW-1] ? -num_w : num_w;
      den_abs_w = den_w[PW-1] ? -den_w : den_w;
   end

   logic [MW-1:0] nmag_ff, dmag_ff;
   logic          neg_ff;
   logic [MW-1:0] u_ff, v_ff;
   logic [KW-1:0] k_ff;
   logic [MW-1:0] g_ff;
   logic [MW-1:0] qn_ff, qd_ff, rn_ff, rd_ff;

   // binary gcd step
   logic [MW-1:0] u_in, v_in;
   logic [KW-1:0] k_in;
   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = KW'(k_ff + 1'b1);
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_in = (u_ff - v_ff) >> 1;
      end else begin
         v_in = (v_ff - u_ff) >> 1;
      end
   end

   // restoring division of both magnitudes by the gcd
   logic [MW:0]   tn_w, td_w;
   logic          gn_w, gd_w;
   always_comb begin
      tn_w = {rn_ff, qn_ff[MW-1]};
      td_w = {rd_ff, qd_ff[MW-1]};
      gn_w = tn_w >= {1'b0, g_ff};
      gd_w = td_w >= {1'b0, g_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.form) begin
         nmag_ff <= num_abs_w[MW-1:0];
         dmag_ff <= den_abs_w[MW-1:0];
         u_ff    <= num_abs_w[MW-1:0];
         v_ff    <= den_abs_w[MW-1:0];
         k_ff    <= '0;
         neg_ff  <= num_w[PW-1] ^ den_w[PW-1];
      end else if (cmd.gcd_step) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
      end
      if (cmd.div_init) begin
         g_ff  <= u_ff << k_ff;
         qn_ff <= nmag_ff;
         qd_ff <= dmag_ff;
         rn_ff <= '0;
         rd_ff <= '0;
      end else if (cmd.div_step) begin
         rn_ff <= gn_w ? MW'(tn_w - {1'b0, g_ff}) : tn_w[MW-1:0];
         rd_ff <= gd_w ? MW'(td_w - {1'b0, g_ff}) : td_w[MW-1:0];
         qn_ff <= {qn_ff[MW-2:0], gn_w};
         qd_ff <= {qd_ff[MW-2:0], gd_w};
      end
   end

   assign status.bad_input = (err_w != STS_OK);
   assign status.num_zero  = (nmag_ff == '0);
   assign status.gcd_done  = (u_ff == v_ff);

   // fit the signed quotient to the result fields
   logic signed [MW:0]         snum_w;
   logic [RES_NUM_WIDTH-1:0]   fit_num_w;
   logic [RES_DEN_WIDTH-1:0]   fit_den_w;

   assign snum_w = neg_ff ? -signed'({1'b0, qn_ff}) : signed'({1'b0, qn_ff});

   if (MW + 1 >= RES_NUM_WIDTH) begin : g_num_trunc
      assign fit_num_w = snum_w[RES_NUM_WIDTH-1:0];
   end else begin : g_num_ext
      assign fit_num_w = {{(RES_NUM_WIDTH-MW-1){snum_w[MW]}}, snum_w};
   end

   if (MW >= RES_DEN_WIDTH) begin : g_den_trunc
      assign fit_den_w = qd_ff[RES_DEN_WIDTH-1:0];
   end else begin : g_den_ext
      assign fit_den_w = {{(RES_DEN_WIDTH-MW){1'b0}}, qd_ff};
   end

   // result register
   logic [RES_NUM_WIDTH-1:0] res_num_ff;
   logic [RES_DEN_WIDTH-1:0] res_den_ff;
   status_type               res_sts_ff;

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (err_w != STS_OK) begin
            res_num_ff <= '0;
            res_den_ff <= '0;
         end else if (nmag_ff == '0) begin
            res_num_ff <= '0;
            res_den_ff <= RES_DEN_WIDTH'(1);
         end else begin
            res_num_ff <= fit_num_w;
            res_den_ff <= fit_den_w;
         end
         res_sts_ff <= err_w;
      end
   end

   assign result_num    = res_num_ff;
   assign result_den    = res_den_ff;
   assign result_status = res_sts_ff;

endmodule

// File: design/rar_ctrl.sv
module rar_ctrl import rar_pkg::*; #(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   localparam int MW = 2 * OPERAND_WIDTH - 1;
   localparam int CW = $clog2(MW + 1);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mul_sel  = MS_AX;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL_AX;
            end
         end
         S_MUL_AX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_AX;
            state_in    = S_MUL_BC;
         end
         S_MUL_BC: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_BC;
            state_in    = S_MUL_BD;
         end
         S_MUL_BD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_BD;
            state_in    = S_FORM;
         end
         S_FORM: begin
            cmd.form = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (status.bad_input || status.num_zero) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = CW'(cnt_ff + 1'b1);
            if (cnt_ff == CW'(MW - 1)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/rational_arith_reduce_core.sv
// Rational add/sub/mul/div of two fractions, result reduced by its gcd.
// Sequence: 3 multiply, form, check, gcd (one step at a time until done), divide and
//   finish; error and zero-numerator beats skip gcd and divide.
// Throughput: one beat at a time, next accepted in the idle state entered as the response is loaded;
//   a stalled response holds the finish state. Reset (sync, active high) clears control.
module rational_arith_reduce_core import rar_pkg::*; #(
   parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // request channel
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // left_num, left_den, right_num, right_den (zero padded)
   input  logic [((4*OPERAND_WIDTH-2+7)/8)*8-1:0]     req_tdata,
   // opcode
   input  logic [OPCODE_WIDTH-1:0]                    req_tuser,
   // response channel
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // result_num, result_den (zero padded)
   output logic [((RES_NUM_WIDTH+RES_DEN_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [STATUS_WIDTH-1:0]                    rsp_tuser
);

   localparam int W        = OPERAND_WIDTH;
   localparam int OUT_BITS = ((RES_NUM_WIDTH + RES_DEN_WIDTH + 7) / 8) * 8;

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   logic [RES_NUM_WIDTH-1:0] result_num;
   logic [RES_DEN_WIDTH-1:0] result_den;

   rar_ctrl #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .status    (dp_status)
   );

   // beat fields are captured in the datapath when the controller loads
   rar_datapath #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .opcode        (req_tuser),
      .left_num      (req_tdata[W-1:0]),
      .left_den      (req_tdata[2*W-2:W]),
      .right_num     (req_tdata[3*W-2:2*W-1]),
      .right_den     (req_tdata[4*W-3:3*W-1]),
      .cmd           (cmd),
      .status        (dp_status),
      .result_num    (result_num),
      .result_den    (result_den),
      .result_status (rsp_tuser)
   );

   assign rsp_tdata = OUT_BITS'({result_den, result_num});

endmodule
